// ===== src/acpc_pkg.sv =====
package acpc_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int MAX_WIDTH   = 1024;
    localparam int COUNT_BITS  = 20;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = 11;
    localparam int COLOR_W = 24;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_PIXEL  = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_COMMON = 2'd3;

    localparam logic [WID_W-1:0] WIDTH_RESET = WID_W'(MAX_WIDTH);

    typedef struct packed {
        logic [1:0]         action;
        logic [COLOR_W-1:0] pixel_color;
        logic [5:0]         entry_index;
    } in_beat_t;

    typedef struct packed {
        logic [6:0]            entry_total;
        logic                  table_overflow;
        logic                  entry_valid;
        logic [COLOR_W-1:0]    own_color;
        logic [COLOR_W-1:0]    neighbor_color;
        logic [1:0]            direction;
        logic [COUNT_BITS-1:0] occurrences;
    } out_beat_t;

    typedef struct packed {
        logic [COLOR_W-1:0] own;
        logic [COLOR_W-1:0] nb;
        logic [1:0]         dir;
    } triple_key_t;

    typedef struct packed {
        triple_key_t           key;
        logic [COUNT_BITS-1:0] count;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic       start;
        logic       line_access;
        logic [1:0] trip_sel;
        logic       trip_exec;
        logic       inc_write;
        logic       pixel_commit;
        logic       rd_entry;
        logic       scan_rd;
        logic       scan_cmp;
        logic       best_rd;
        logic       out_blank;
        logic       out_entry;
    } acpc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic trip_hit;
        logic scan_more;
        logic used_nz;
        logic out_free;
    } acpc_stat_t;

endpackage

// ===== src/acpc_ctrl.sv =====
module acpc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         in_action,
    output logic               in_stall,
    input  acpc_pkg::acpc_stat_t stat,
    output acpc_pkg::acpc_cmd_t  cmd
);
    import acpc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_LINE      = 10'b0000000010,
        S_TRIP      = 10'b0000000100,
        S_INC       = 10'b0000001000,
        S_COMMIT    = 10'b0000010000,
        S_RD        = 10'b0000100000,
        S_SCAN_RD   = 10'b0001000000,
        S_SCAN_CMP  = 10'b0010000000,
        S_FIN_BLANK = 10'b0100000000,
        S_FIN_ENTRY = 10'b1000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] trip_reg, trip_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        trip_next  = trip_reg;
        cmd        = '0;
        cmd.trip_sel = trip_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    case (in_action)
                        ACT_CLEAR:  state_next = S_FIN_BLANK;
                        ACT_PIXEL:  state_next = S_LINE;
                        ACT_READ:   state_next = S_RD;
                        ACT_COMMON: state_next = S_SCAN_RD;
                        default:    state_next = S_FIN_BLANK;
                    endcase
                end
            end
            S_LINE:
            begin
                cmd.line_access = 1'b1;
                trip_next  = 2'd0;
                state_next = S_TRIP;
            end
            S_TRIP:
            begin
                cmd.trip_exec = 1'b1;
                if (stat.trip_hit)
                    state_next = S_INC;
                else if (trip_reg == DIR_DOWN)
                    state_next = S_COMMIT;
                else
                    trip_next = trip_reg + 2'd1;
            end
            S_INC:
            begin
                cmd.inc_write = 1'b1;
                if (trip_reg == DIR_DOWN)
                    state_next = S_COMMIT;
                else
                begin
                    trip_next  = trip_reg + 2'd1;
                    state_next = S_TRIP;
                end
            end
            S_COMMIT:
            begin
                cmd.pixel_commit = 1'b1;
                state_next = S_FIN_BLANK;
            end
            S_RD:
            begin
                cmd.rd_entry = 1'b1;
                state_next = S_FIN_ENTRY;
            end
            S_SCAN_RD:
            begin
                if (stat.scan_more)
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_CMP;
                end
                else if (stat.used_nz)
                begin
                    cmd.best_rd = 1'b1;
                    state_next  = S_FIN_ENTRY;
                end
                else
                    state_next = S_FIN_BLANK;
            end
            S_SCAN_CMP:
            begin
                cmd.scan_cmp = 1'b1;
                state_next = S_SCAN_RD;
            end
            S_FIN_BLANK:
            begin
                if (stat.out_free)
                begin
                    cmd.out_blank = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIN_ENTRY:
            begin
                if (stat.out_free)
                begin
                    cmd.out_entry = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            trip_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            trip_reg  <= trip_next;
        end
    end

endmodule

// ===== src/acpc_datapath.sv =====
module acpc_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  acpc_pkg::in_beat_t      in_data,
    input  logic                    cfg_write_en,
    input  logic [10:0]             cfg_write_data,
    input  acpc_pkg::acpc_cmd_t     cmd,
    output acpc_pkg::acpc_stat_t    stat,
    output logic                    out_valid,
    input  logic                    out_stall,
    output acpc_pkg::out_beat_t     out_data
);
    import acpc_pkg::*;

    logic [WID_W-1:0]      width_reg;
    logic [COLOR_W-1:0]    pix_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [USED_W-1:0]     used_reg;
    logic                  ovf_reg;
    logic [COLOR_W-1:0]    left_reg;
    logic [COL_W-1:0]      col_reg;
    logic                  first_reg;
    logic [COLOR_W-1:0]    up_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [USED_W-1:0]     scan_k_reg;
    logic [IDX_W-1:0]      scan_tag_reg;
    logic [IDX_W-1:0]      best_reg;
    logic [COUNT_BITS-1:0] best_cnt_reg;
    logic                  ent_ok_reg;
    logic                  out_valid_reg;
    out_beat_t             out_reg;
    entry_t                rdata_reg;

    triple_key_t           key_reg [TABLE_DEPTH];
    entry_t                entry_mem [TABLE_DEPTH];
    logic [COLOR_W-1:0]    line_mem [MAX_WIDTH];

    triple_key_t           cur_key;
    logic                  trip_en;
    logic [TABLE_DEPTH-1:0] hit_vec;
    logic                  hit_any;
    logic [IDX_W-1:0]      hit_idx;
    logic                  full;
    logic                  do_insert;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    entry_t                mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [WID_W-1:0]      eff_width;
    logic [WID_W-1:0]      col_plus;
    logic                  out_free;
    out_beat_t             out_next;

    // current triple of the pixel
    always_comb
    begin
        case (cmd.trip_sel)
            DIR_LEFT:  cur_key = '{own: pix_reg,  nb: left_reg, dir: DIR_LEFT};
            DIR_RIGHT: cur_key = '{own: left_reg, nb: pix_reg,  dir: DIR_RIGHT};
            DIR_UP:    cur_key = '{own: pix_reg,  nb: up_reg,   dir: DIR_UP};
            default:   cur_key = '{own: up_reg,   nb: pix_reg,  dir: DIR_DOWN};
        endcase
        trip_en = cmd.trip_sel[1] ? !first_reg : (col_reg != '0);
    end

    // parallel compare over the held keys
    always_comb
    begin
        for (int k = 0; k < TABLE_DEPTH; k++)
            hit_vec[k] = (USED_W'(k) < used_reg) && (key_reg[k] == cur_key);
        hit_idx = '0;
        for (int k = TABLE_DEPTH - 1; k >= 0; k--)
            if (hit_vec[k])
                hit_idx = IDX_W'(k);
        hit_any = |hit_vec;
    end

    assign full      = (used_reg == USED_W'(TABLE_DEPTH));
    assign do_insert = cmd.trip_exec && trip_en && !hit_any && !full;
    assign cnt_inc   = (&rdata_reg.count) ? rdata_reg.count : rdata_reg.count + 1'b1;

    always_comb
    begin
        mem_we    = do_insert || cmd.inc_write;
        mem_waddr = do_insert ? used_reg[IDX_W-1:0] : hit_idx_reg;
        if (do_insert)
        begin
            mem_wdata.key   = cur_key;
            mem_wdata.count = COUNT_BITS'(1);
        end
        else
        begin
            mem_wdata.key   = rdata_reg.key;
            mem_wdata.count = cnt_inc;
        end
        mem_re    = cmd.rd_entry || cmd.scan_rd || cmd.best_rd
                    || (cmd.trip_exec && trip_en && hit_any);
        if (cmd.rd_entry)
            mem_raddr = idx_reg;
        else if (cmd.scan_rd)
            mem_raddr = scan_k_reg[IDX_W-1:0];
        else if (cmd.best_rd)
            mem_raddr = best_reg;
        else
            mem_raddr = hit_idx;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            entry_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= entry_mem[mem_raddr];
        if (do_insert)
            key_reg[used_reg[IDX_W-1:0]] <= cur_key;
    end

    // line store, old value read while the new pixel goes in
    always_ff @(posedge clk)
    begin
        if (cmd.line_access)
        begin
            up_reg            <= line_mem[col_reg];
            line_mem[col_reg] <= pix_reg;
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            eff_width = WID_W'(1);
        else if (width_reg > WID_W'(MAX_WIDTH))
            eff_width = WID_W'(MAX_WIDTH);
        else
            eff_width = width_reg;
        col_plus = WID_W'(col_reg) + WID_W'(1);
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            pix_reg <= in_data.pixel_color;
            idx_reg <= in_data.entry_index[IDX_W-1:0];
        end
        if (cmd.trip_exec && hit_any)
            hit_idx_reg <= hit_idx;
        if (cmd.scan_rd)
            scan_tag_reg <= scan_k_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            used_reg     <= '0;
            ovf_reg      <= 1'b0;
            left_reg     <= '0;
            col_reg      <= '0;
            first_reg    <= 1'b1;
            scan_k_reg   <= '0;
            best_reg     <= '0;
            best_cnt_reg <= '0;
            ent_ok_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                width_reg <= cfg_write_data;
            if (cmd.start)
            begin
                scan_k_reg   <= '0;
                best_reg     <= '0;
                best_cnt_reg <= '0;
                if (in_data.action == ACT_CLEAR)
                begin
                    used_reg  <= '0;
                    ovf_reg   <= 1'b0;
                    left_reg  <= '0;
                    col_reg   <= '0;
                    first_reg <= 1'b1;
                end
            end
            if (do_insert)
                used_reg <= used_reg + 1'b1;
            if (cmd.trip_exec && trip_en && !hit_any && full)
                ovf_reg <= 1'b1;
            if (cmd.pixel_commit)
            begin
                left_reg <= pix_reg;
                if (col_plus >= eff_width)
                begin
                    col_reg   <= '0;
                    first_reg <= 1'b0;
                end
                else
                    col_reg <= col_plus[COL_W-1:0];
            end
            if (cmd.scan_rd)
                scan_k_reg <= scan_k_reg + 1'b1;
            if (cmd.scan_cmp && (rdata_reg.count > best_cnt_reg))
            begin
                best_reg     <= scan_tag_reg;
                best_cnt_reg <= rdata_reg.count;
            end
            if (cmd.rd_entry)
                ent_ok_reg <= (USED_W'(idx_reg) < used_reg);
            if (cmd.best_rd)
                ent_ok_reg <= 1'b1;
        end
    end

    // output register
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_next = '0;
        out_next.entry_total    = 7'(used_reg);
        out_next.table_overflow = ovf_reg;
        if (cmd.out_entry && ent_ok_reg)
        begin
            out_next.entry_valid    = 1'b1;
            out_next.own_color      = rdata_reg.key.own;
            out_next.neighbor_color = rdata_reg.key.nb;
            out_next.direction      = rdata_reg.key.dir;
            out_next.occurrences    = rdata_reg.count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_entry || cmd.out_blank)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_entry || cmd.out_blank)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign stat.trip_hit  = trip_en && hit_any;
    assign stat.scan_more = (scan_k_reg < used_reg);
    assign stat.used_nz   = (used_reg != '0);
    assign stat.out_free  = out_free;

endmodule

// ===== src/adjacent_color_pair_counter_unit.sv =====
// a pixel walks its triples in order
// (line store access, one table compare per triple, one extra count update per hit)
// a most-common query does one table memory read per entry scanned
// one item in flight; a new beat is taken while the last result waits at the output
// rst_n async active low: table empty, overflow clear, width 1024, first row
module adjacent_color_pair_counter_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  acpc_pkg::in_beat_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output acpc_pkg::out_beat_t  out_data,
    input  logic                 cfg_write_en,
    input  logic [10:0]          cfg_write_data
);
    import acpc_pkg::*;

    // command and status between sequencer and datapath
    acpc_cmd_t  cmd;
    acpc_stat_t stat;

    // sequencer: walks the four triples of a pixel, the scan and the read
    acpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_action (in_data.action),
        .in_stall  (in_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: key compare array, entry memory, line store, output beat register
    acpc_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_data        (in_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data)
    );

`ifndef SYNTH
    // an accepted beat keeps the input stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

    // table fill never passes its depth
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.entry_total <= 7'(TABLE_DEPTH))
        else $error("entry total above depth");

    // a dropped triple only happens on a full table
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.table_overflow |-> out_data.entry_total == 7'(TABLE_DEPTH))
        else $error("overflow with room in table");

    // no entry means all entry fields zero
    a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.entry_valid |->
            out_data.own_color == '0 && out_data.neighbor_color == '0
            && out_data.direction == '0 && out_data.occurrences == '0)
        else $error("blank beat carries entry data");
`endif

endmodule

// ===== tb/sv/adjacent_color_pair_counter_unit_test.sv =====
`timescale 1ns / 100ps

module adjacent_color_pair_counter_unit_test;
    import acpc_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

    // shadow copy of the pair histogram, predicts one result beat per input beat
    class pair_histogram_model;
        triple_key_t           keys [TABLE_DEPTH];
        logic [COUNT_BITS-1:0] counts [TABLE_DEPTH];
        int                    used;
        logic [COLOR_W-1:0]    line_colors [MAX_WIDTH];
        logic [COLOR_W-1:0]    left_color;
        int                    column;
        bit                    first_row;
        bit                    overflow;
        int                    row_width;
        out_beat_t             pending_beats [$];
        int                    mismatches;

        function new();
            used       = 0;
            left_color = '0;
            column     = 0;
            first_row  = 1;
            overflow   = 0;
            row_width  = MAX_WIDTH;
            mismatches = 0;
        endfunction

        function void set_width(logic [WID_W-1:0] w);
            row_width = w;
        endfunction

        function void tally(logic [COLOR_W-1:0] own, logic [COLOR_W-1:0] nb, logic [1:0] dir);
            triple_key_t k;
            k = '{own: own, nb: nb, dir: dir};
            for (int i = 0; i < used; i++)
            begin
                if (keys[i] == k)
                begin
                    if (counts[i] != COUNT_TOP)
                        counts[i]++;
                    return;
                end
            end
            if (used < TABLE_DEPTH)
            begin
                keys[used]   = k;
                counts[used] = 1;
                used++;
            end
            else
                overflow = 1;
        endfunction

        function void note_input(in_beat_t b);
            out_beat_t          r;
            int                 w;
            int                 best;
            int                 pick;
            logic [COLOR_W-1:0] up;
            r    = '0;
            pick = -1;
            case (b.action)
                ACT_CLEAR:
                begin
                    used       = 0;
                    overflow   = 0;
                    left_color = '0;
                    column     = 0;
                    first_row  = 1;
                end
                ACT_PIXEL:
                begin
                    w = row_width;
                    if (w == 0)
                        w = 1;
                    if (w > MAX_WIDTH)
                        w = MAX_WIDTH;
                    if (column > 0)
                    begin
                        tally(b.pixel_color, left_color, DIR_LEFT);
                        tally(left_color, b.pixel_color, DIR_RIGHT);
                    end
                    if (!first_row)
                    begin
                        up = line_colors[column];
                        tally(b.pixel_color, up, DIR_UP);
                        tally(up, b.pixel_color, DIR_DOWN);
                    end
                    line_colors[column] = b.pixel_color;
                    left_color          = b.pixel_color;
                    if (column + 1 >= w)
                    begin
                        column    = 0;
                        first_row = 0;
                    end
                    else
                        column++;
                end
                ACT_READ:
                    if (b.entry_index < used)
                        pick = b.entry_index;
                default:
                    if (used > 0)
                    begin
                        best = 0;
                        for (int i = 1; i < used; i++)
                            if (counts[i] > counts[best])
                                best = i;
                        pick = best;
                    end
            endcase
            if (pick >= 0)
            begin
                r.entry_valid    = 1;
                r.own_color      = keys[pick].own;
                r.neighbor_color = keys[pick].nb;
                r.direction      = keys[pick].dir;
                r.occurrences    = counts[pick];
            end
            r.entry_total    = 7'(used);
            r.table_overflow = overflow;
            pending_beats = {pending_beats, r};
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_result(out_beat_t got);
            out_beat_t want;
            if (pending_beats.size() == 0)
            begin
                report($sformatf("unexpected result beat %h", got));
                return;
            end
            want = pending_beats.pop_front();
            if (got.entry_total !== want.entry_total)
                report($sformatf("entry_total %0d, want %0d", got.entry_total, want.entry_total));
            if (got.table_overflow !== want.table_overflow)
                report($sformatf("table_overflow %b, want %b",
                                 got.table_overflow, want.table_overflow));
            if (got.entry_valid !== want.entry_valid)
                report($sformatf("entry_valid %b, want %b", got.entry_valid, want.entry_valid));
            if (got.own_color !== want.own_color)
                report($sformatf("own_color %h, want %h", got.own_color, want.own_color));
            if (got.neighbor_color !== want.neighbor_color)
                report($sformatf("neighbor_color %h, want %h",
                                 got.neighbor_color, want.neighbor_color));
            if (got.direction !== want.direction)
                report($sformatf("direction %0d, want %0d", got.direction, want.direction));
            if (got.occurrences !== want.occurrences)
                report($sformatf("occurrences %0d, want %0d", got.occurrences, want.occurrences));
        endtask
    endclass

    logic             clk = 0;
    logic             rst_n = 0;
    logic             in_valid = 0;
    logic             in_stall;
    in_beat_t         in_data = '0;
    logic             out_valid;
    logic             out_stall = 0;
    out_beat_t        out_data;
    logic             cfg_write_en = 0;
    logic [WID_W-1:0] cfg_write_data = '0;

    pair_histogram_model histogram = new();

    // calm stretches: no gaps on either side
    bit calm = 0;
    int stall_left = 0;
    logic [COLOR_W-1:0] palette [4];

    adjacent_color_pair_counter_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data)
    );

    always #5 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1;
        end
        else
        begin
            out_stall  <= 0;
            stall_left <= pick_gap();
        end
    end

    // result beats are checked on the falling edge before the edge that takes them
    always @(negedge clk)
        if (rst_n && out_valid && !out_stall)
            histogram.check_result(out_data);

    // one input beat, with an optional leading gap; returns at the accepting edge
    task send_beat(in_beat_t b);
        int  gap;
        bit  taken;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        in_data  <= b;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        histogram.note_input(b);
    endtask

    task send(logic [1:0] act, logic [COLOR_W-1:0] color, logic [5:0] idx);
        in_beat_t b;
        b.action      = act;
        b.pixel_color = color;
        b.entry_index = idx;
        send_beat(b);
    endtask

    // hold the sender until every result is back, then let the pipe settle
    task wait_idle();
        in_valid <= 0;
        while (histogram.pending_beats.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task set_width(logic [WID_W-1:0] w);
        wait_idle();
        cfg_write_en   <= 1;
        cfg_write_data <= w;
        @(posedge clk);
        cfg_write_en <= 0;
        histogram.set_width(w);
        send(ACT_CLEAR, '0, '0);
    endtask

    function automatic logic [COLOR_W-1:0] pick_color();
        if ($urandom_range(0, 9) == 0)
            return COLOR_W'($urandom());
        return palette[$urandom_range(0, 3)];
    endfunction

    task random_phase(int count);
        int r;
        for (int p = 0; p < 4; p++)
            palette[p] = COLOR_W'($urandom());
        for (int n = 0; n < count; n++)
        begin
            if (n % 60 == 0)
                calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 70)
                send(ACT_PIXEL, pick_color(), 6'($urandom()));
            else if (r < 88)
                send(ACT_READ, COLOR_W'($urandom()), 6'($urandom()));
            else if (r < 98)
                send(ACT_COMMON, COLOR_W'($urandom()), 6'($urandom()));
            else
                send(ACT_CLEAR, COLOR_W'($urandom()), 6'($urandom()));
            if (n == count / 2 && $urandom_range(0, 1) == 1)
                wait_idle();
        end
        calm = 0;
    endtask

    initial
    begin
        int waited;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty table, extreme colors and indexes, default width
        send(ACT_COMMON, '0, '0);
        send(ACT_READ, '0, 6'd0);
        send(ACT_READ, '1, 6'd63);
        send(ACT_PIXEL, 24'h000000, '0);
        send(ACT_PIXEL, 24'hFFFFFF, '0);
        send(ACT_PIXEL, 24'h000000, '1);
        send(ACT_PIXEL, 24'hFFFFFF, '0);
        send(ACT_COMMON, '0, '0);
        send(ACT_READ, '0, 6'd0);
        send(ACT_READ, '0, 6'd1);
        send(ACT_READ, '0, 6'd2);
        send(ACT_READ, '0, 6'd3);
        send(ACT_CLEAR, '0, '0);
        send(ACT_READ, '0, 6'd0);

        // directed: two-wide rows bring in the up and down pairs
        set_width(11'd2);
        send(ACT_PIXEL, 24'hFF0000, '0);
        send(ACT_PIXEL, 24'h00FF00, '0);
        send(ACT_PIXEL, 24'h0000FF, '0);
        send(ACT_PIXEL, 24'hFFFFFF, '0);
        send(ACT_PIXEL, 24'h000000, '0);
        send(ACT_COMMON, '0, '0);
        send(ACT_READ, '0, 6'd7);
        send(ACT_READ, '0, 6'd63);

        // random phases over width extremes and a few ordinary ones
        set_width(11'd1);
        random_phase(200);
        set_width(11'd0);
        random_phase(180);
        set_width(11'd3);
        random_phase(220);
        set_width(11'd2047);
        random_phase(150);
        set_width(11'd5);
        random_phase(250);
        set_width(11'd1024);
        random_phase(120);
        set_width(11'($urandom_range(2, 16)));
        random_phase(250);
        set_width(11'd2);
        random_phase(200);

        in_valid <= 0;
        waited = 0;
        while (histogram.pending_beats.size() > 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);
        while (histogram.pending_beats.size() > 0)
            histogram.report($sformatf("result never arrived: %h",
                                       histogram.pending_beats.pop_front()));
        if (histogram.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
